// ===== rtl/core/kab_pkg.sv =====
// Shared types, constants and helpers for the angle/bias Kalman estimator.
// Holds the word formats, register indexes, sequencer micro-ops and the
// saturation helper. No dependencies.
`default_nettype none

package kab_pkg;

  // Fixed-point format
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int ACC_WIDTH  = 2 * DATA_WIDTH;
  localparam int CFG_WIDTH  = 31;
  localparam int CFG_IDX_W  = 2;

  typedef logic signed [DATA_WIDTH-1:0] word_t;
  typedef logic [CFG_WIDTH-1:0]         cfg_word_t;

  localparam word_t WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam word_t WORD_ONE = word_t'(64'd1 << FRAC_BITS);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_Q_ANGLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Q_BIAS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_R_MEAS    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 2'd3;

  localparam cfg_word_t Q_ANGLE_RST   = 31'd66;
  localparam cfg_word_t Q_BIAS_RST    = 31'd197;
  localparam cfg_word_t R_MEAS_RST    = 31'd32768;
  localparam cfg_word_t TIME_STEP_RST = 31'd3277;

  // Channel payloads
  typedef struct packed {
    word_t measured_angle;
    word_t gyro_rate;
  } sample_t;

  typedef struct packed {
    word_t angle_estimate;
    word_t bias_estimate;
  } estimate_t;

  // Arithmetic unit operations
  typedef logic [2:0] alu_op_t;
  localparam alu_op_t OP_ADD = 3'd0;
  localparam alu_op_t OP_SUB = 3'd1;
  localparam alu_op_t OP_ACC = 3'd2;  // accumulator plus operand b, unsaturated
  localparam alu_op_t OP_MUL = 3'd3;
  localparam alu_op_t OP_DIV = 3'd4;

  // Operand sources and write-back targets
  typedef logic [4:0] src_t;
  localparam src_t SRC_ANGLE = 5'd0;
  localparam src_t SRC_BIAS  = 5'd1;
  localparam src_t SRC_C00   = 5'd2;
  localparam src_t SRC_C01   = 5'd3;
  localparam src_t SRC_C10   = 5'd4;
  localparam src_t SRC_C11   = 5'd5;
  localparam src_t SRC_MEAS  = 5'd6;
  localparam src_t SRC_RATE  = 5'd7;
  localparam src_t SRC_QA    = 5'd8;
  localparam src_t SRC_QB    = 5'd9;
  localparam src_t SRC_R     = 5'd10;
  localparam src_t SRC_DT    = 5'd11;
  localparam src_t SRC_T     = 5'd12;
  localparam src_t SRC_ANGP  = 5'd13;
  localparam src_t SRC_P11DT = 5'd14;
  localparam src_t SRC_P00   = 5'd15;
  localparam src_t SRC_P01   = 5'd16;
  localparam src_t SRC_P10   = 5'd17;
  localparam src_t SRC_P11   = 5'd18;
  localparam src_t SRC_DEN   = 5'd19;
  localparam src_t SRC_INNOV = 5'd20;
  localparam src_t SRC_K1    = 5'd21;
  localparam src_t SRC_K2    = 5'd22;
  localparam src_t SRC_M     = 5'd23;

  typedef struct packed {
    alu_op_t op;
    src_t    src_a;
    src_t    src_b;
    src_t    dst;
    logic    wr;
  } uop_t;

  // Divider handshake status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  localparam int N_STEPS = 29;
  typedef logic [4:0] step_t;
  localparam step_t STEP_LAST = step_t'(N_STEPS - 1);

  // Saturate a wide signed value to the word range
  function automatic word_t sat_word(input logic signed [ACC_WIDTH-1:0] x);
    if ((&x[ACC_WIDTH-1:DATA_WIDTH-1]) || !(|x[ACC_WIDTH-1:DATA_WIDTH-1]))
      return x[DATA_WIDTH-1:0];
    else if (x[ACC_WIDTH-1])
      return WORD_MIN;
    else
      return WORD_MAX;
  endfunction

  function automatic uop_t mk_uop(input alu_op_t op, input src_t a, input src_t b,
                                  input src_t d, input logic wr);
    uop_t u;
    u.op    = op;
    u.src_a = a;
    u.src_b = b;
    u.dst   = d;
    u.wr    = wr;
    return u;
  endfunction

  // Micro-program: predict, then gains, then state and covariance update
  function automatic uop_t ucode(input step_t s);
    uop_t u;
    u = mk_uop(OP_ADD, SRC_T, SRC_T, SRC_T, 1'b0);
    unique case (s)
      5'd0:  u = mk_uop(OP_SUB, SRC_RATE,  SRC_BIAS,  SRC_T,     1'b1);
      5'd1:  u = mk_uop(OP_MUL, SRC_T,     SRC_DT,    SRC_T,     1'b1);
      5'd2:  u = mk_uop(OP_ADD, SRC_ANGLE, SRC_T,     SRC_ANGP,  1'b1);
      5'd3:  u = mk_uop(OP_MUL, SRC_C11,   SRC_DT,    SRC_P11DT, 1'b1);
      5'd4:  u = mk_uop(OP_ADD, SRC_C01,   SRC_C10,   SRC_T,     1'b1);
      5'd5:  u = mk_uop(OP_MUL, SRC_T,     SRC_DT,    SRC_T,     1'b1);
      5'd6:  u = mk_uop(OP_MUL, SRC_P11DT, SRC_DT,    SRC_M,     1'b1);
      // P00 is one four-term sum saturated once at the end
      5'd7:  u = mk_uop(OP_SUB, SRC_C00,   SRC_T,     SRC_T,     1'b0);
      5'd8:  u = mk_uop(OP_ACC, SRC_T,     SRC_M,     SRC_T,     1'b0);
      5'd9:  u = mk_uop(OP_ACC, SRC_T,     SRC_QA,    SRC_P00,   1'b1);
      5'd10: u = mk_uop(OP_SUB, SRC_C01,   SRC_P11DT, SRC_P01,   1'b1);
      5'd11: u = mk_uop(OP_SUB, SRC_C10,   SRC_P11DT, SRC_P10,   1'b1);
      5'd12: u = mk_uop(OP_ADD, SRC_C11,   SRC_QB,    SRC_P11,   1'b1);
      5'd13: u = mk_uop(OP_ADD, SRC_P00,   SRC_R,     SRC_DEN,   1'b1);
      5'd14: u = mk_uop(OP_SUB, SRC_MEAS,  SRC_ANGP,  SRC_INNOV, 1'b1);
      5'd15: u = mk_uop(OP_DIV, SRC_P00,   SRC_DEN,   SRC_K1,    1'b1);
      5'd16: u = mk_uop(OP_DIV, SRC_P10,   SRC_DEN,   SRC_K2,    1'b1);
      5'd17: u = mk_uop(OP_MUL, SRC_K1,    SRC_INNOV, SRC_T,     1'b1);
      5'd18: u = mk_uop(OP_ADD, SRC_ANGP,  SRC_T,     SRC_ANGLE, 1'b1);
      5'd19: u = mk_uop(OP_MUL, SRC_K2,    SRC_INNOV, SRC_T,     1'b1);
      5'd20: u = mk_uop(OP_ADD, SRC_BIAS,  SRC_T,     SRC_BIAS,  1'b1);
      5'd21: u = mk_uop(OP_MUL, SRC_K1,    SRC_P00,   SRC_T,     1'b1);
      5'd22: u = mk_uop(OP_SUB, SRC_P00,   SRC_T,     SRC_C00,   1'b1);
      5'd23: u = mk_uop(OP_MUL, SRC_K1,    SRC_P01,   SRC_T,     1'b1);
      5'd24: u = mk_uop(OP_SUB, SRC_P01,   SRC_T,     SRC_C01,   1'b1);
      5'd25: u = mk_uop(OP_MUL, SRC_K2,    SRC_P00,   SRC_T,     1'b1);
      5'd26: u = mk_uop(OP_SUB, SRC_P10,   SRC_T,     SRC_C10,   1'b1);
      5'd27: u = mk_uop(OP_MUL, SRC_K2,    SRC_P01,   SRC_T,     1'b1);
      5'd28: u = mk_uop(OP_SUB, SRC_P11,   SRC_T,     SRC_C11,   1'b1);
      default: u = mk_uop(OP_ADD, SRC_T, SRC_T, SRC_T, 1'b0);
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/kab_stream_if.sv =====
// Valid/ready stream interface used for the sample and estimate channels.
// The payload type is a parameter; payload structs come from kab_pkg.
`default_nettype none

interface kab_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/kab_alu.sv =====
// Shared arithmetic unit: add, subtract, accumulate and Q-format multiply.
// One registered accumulator; rounding and saturation on the read side. Uses kab_pkg.
`default_nettype none

module kab_alu (
  input  logic             clk,
  input  logic             go,
  input  kab_pkg::alu_op_t op,
  input  kab_pkg::word_t   a,
  input  kab_pkg::word_t   b,
  output kab_pkg::word_t   res
);
  import kab_pkg::*;

  localparam logic signed [ACC_WIDTH-1:0] HALF_LSB = ACC_WIDTH'(1) << (FRAC_BITS - 1);

  logic signed [ACC_WIDTH-1:0] acc;
  logic signed [ACC_WIDTH-1:0] acc_next;
  logic signed [ACC_WIDTH-1:0] rnd;
  logic signed [ACC_WIDTH-1:0] shifted;
  logic                        is_mul;

  // raw result: exact sum or exact product
  always_comb begin
    unique case (op)
      OP_ADD:  acc_next = ACC_WIDTH'(a) + ACC_WIDTH'(b);
      OP_SUB:  acc_next = ACC_WIDTH'(a) - ACC_WIDTH'(b);
      OP_ACC:  acc_next = acc + ACC_WIDTH'(b);
      OP_MUL:  acc_next = ACC_WIDTH'(a) * ACC_WIDTH'(b);
      default: acc_next = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (go) begin
      acc    <= acc_next;
      is_mul <= (op == OP_MUL);
    end
  end

  // products: round to nearest, ties upward, then drop the fraction
  assign rnd     = acc + HALF_LSB;
  assign shifted = rnd >>> FRAC_BITS;
  assign res     = is_mul ? sat_word(shifted) : sat_word(acc);

endmodule

`default_nettype wire

// ===== rtl/core/kab_div.sv =====
// Serial restoring divider for the gains: (num << FRAC_BITS) / den, truncated
// toward zero and saturated; zero denominator gives zero. Uses kab_pkg.
`default_nettype none

module kab_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  kab_pkg::word_t      num,
  input  kab_pkg::word_t      den,
  output kab_pkg::div_stat_t  stat,
  output kab_pkg::word_t      quot
);
  import kab_pkg::*;

  localparam int MAG_W = DATA_WIDTH;
  localparam int NUM_W = DATA_WIDTH + FRAC_BITS;
  localparam int CNT_W = $clog2(DATA_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [MAG_W-1:0] rem;
  logic [MAG_W-1:0] low;      // numerator bits out, quotient bits in
  logic [MAG_W-1:0] den_mag;
  logic             neg;
  logic             ovf;
  logic             zero;

  logic [MAG_W-1:0] num_mag_s;
  logic [MAG_W-1:0] den_mag_s;
  logic [NUM_W-1:0] num_sh;
  logic [MAG_W-1:0] hi_s;
  logic             ovf_s;
  logic [MAG_W:0]   trial;
  logic             fits;

  // start: magnitudes and early overflow check
  always_comb begin
    num_mag_s = num[DATA_WIDTH-1] ? MAG_W'(-num) : MAG_W'(num);
    den_mag_s = den[DATA_WIDTH-1] ? MAG_W'(-den) : MAG_W'(den);
    num_sh    = {num_mag_s, {FRAC_BITS{1'b0}}};
    hi_s      = MAG_W'(num_sh[NUM_W-1:DATA_WIDTH]);
    ovf_s     = (hi_s >= den_mag_s);
  end

  // one quotient bit per cycle
  assign trial = {rem, low[MAG_W-1]};
  assign fits  = (trial >= {1'b0, den_mag});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if ((den == '0) || ovf_s) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt     <= '0;
      rem     <= hi_s;
      low     <= num_sh[DATA_WIDTH-1:0];
      den_mag <= den_mag_s;
      neg     <= num[DATA_WIDTH-1] ^ den[DATA_WIDTH-1];
      ovf     <= ovf_s;
      zero    <= (den == '0);
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      rem <= fits ? MAG_W'(trial - {1'b0, den_mag}) : trial[MAG_W-1:0];
      low <= {low[MAG_W-2:0], fits};
    end
  end

  // sign and saturation of the magnitude quotient
  always_comb begin
    if (zero)
      quot = '0;
    else if (ovf)
      quot = neg ? WORD_MIN : WORD_MAX;
    else if (neg)
      quot = (low[MAG_W-1] && (low[MAG_W-2:0] != '0)) ? WORD_MIN : word_t'(-low);
    else
      quot = low[MAG_W-1] ? WORD_MAX : word_t'(low);
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

// ===== rtl/core/kalman_angle_bias_estimator.sv =====
// Two-state Kalman filter for tilt angle and gyro bias, Q16.16 words.
// Sequencer and state registers around one shared ALU and a serial divider.
// Uses kab_pkg, kab_stream_if, kab_alu and kab_div.
//
// Usage:
//   sample   : sink stream, one word = measured angle and gyro rate.
//   estimate : source stream, one word = angle and bias after the update.
//   cfg_*    : write-only port for q_angle, q_bias, r_meas and time_step;
//              write only while the filter is idle.
// Operation: one sample at a time. A sample is worked through 29 micro-steps;
// 27 run on the shared ALU (operate, then round and write back where the
// step writes) and the two gain divisions run on the one-bit-per-cycle
// divider; a hand-over state then loads the estimate word into the output
// register once it is free. sample.ready is high only while the sequencer
// is idle.
// The estimate sits in an output register: a stalled receiver does not
// block the next sample, only the hand-over of the following estimate.
// Reset (synchronous) restores the registers to their defaults, the state
// to angle 0, bias 0, covariance identity, and drops any pending estimate.
`default_nettype none

module kalman_angle_bias_estimator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [kab_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  kab_pkg::cfg_word_t                  cfg_data,
  kab_stream_if.sink                          sample,
  kab_stream_if.source                        estimate
);
  import kab_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_WB   = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0] state;
  step_t      step;
  uop_t       uc;

  // configuration
  cfg_word_t q_angle;
  cfg_word_t q_bias;
  cfg_word_t r_meas;
  cfg_word_t time_step;

  // filter state and sample
  word_t angle_st, bias_st, c00, c01, c10, c11;
  word_t meas, rate;

  // scratch words
  word_t t, angp, p11dt, p00, p01, p10, p11, den, innov, k1, k2, m;

  word_t opa, opb, alu_res, div_res, wdata;
  logic  alu_go, div_start, wr_en;
  div_stat_t div_stat;

  logic  out_valid;
  word_t out_angle, out_bias;

  assign uc = ucode(step);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      q_angle   <= Q_ANGLE_RST;
      q_bias    <= Q_BIAS_RST;
      r_meas    <= R_MEAS_RST;
      time_step <= TIME_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_Q_ANGLE:   q_angle   <= cfg_data;
        REG_Q_BIAS:    q_bias    <= cfg_data;
        REG_R_MEAS:    r_meas    <= cfg_data;
        REG_TIME_STEP: time_step <= cfg_data;
        default: ;
      endcase
    end
  end

  // operand A select
  always_comb begin
    unique case (uc.src_a)
      SRC_ANGLE: opa = angle_st;
      SRC_BIAS:  opa = bias_st;
      SRC_C00:   opa = c00;
      SRC_C01:   opa = c01;
      SRC_C10:   opa = c10;
      SRC_C11:   opa = c11;
      SRC_MEAS:  opa = meas;
      SRC_RATE:  opa = rate;
      SRC_QA:    opa = word_t'({1'b0, q_angle});
      SRC_QB:    opa = word_t'({1'b0, q_bias});
      SRC_R:     opa = word_t'({1'b0, r_meas});
      SRC_DT:    opa = word_t'({1'b0, time_step});
      SRC_T:     opa = t;
      SRC_ANGP:  opa = angp;
      SRC_P11DT: opa = p11dt;
      SRC_P00:   opa = p00;
      SRC_P01:   opa = p01;
      SRC_P10:   opa = p10;
      SRC_P11:   opa = p11;
      SRC_DEN:   opa = den;
      SRC_INNOV: opa = innov;
      SRC_K1:    opa = k1;
      SRC_K2:    opa = k2;
      SRC_M:     opa = m;
      default:   opa = '0;
    endcase
  end

  // operand B select
  always_comb begin
    unique case (uc.src_b)
      SRC_ANGLE: opb = angle_st;
      SRC_BIAS:  opb = bias_st;
      SRC_C00:   opb = c00;
      SRC_C01:   opb = c01;
      SRC_C10:   opb = c10;
      SRC_C11:   opb = c11;
      SRC_MEAS:  opb = meas;
      SRC_RATE:  opb = rate;
      SRC_QA:    opb = word_t'({1'b0, q_angle});
      SRC_QB:    opb = word_t'({1'b0, q_bias});
      SRC_R:     opb = word_t'({1'b0, r_meas});
      SRC_DT:    opb = word_t'({1'b0, time_step});
      SRC_T:     opb = t;
      SRC_ANGP:  opb = angp;
      SRC_P11DT: opb = p11dt;
      SRC_P00:   opb = p00;
      SRC_P01:   opb = p01;
      SRC_P10:   opb = p10;
      SRC_P11:   opb = p11;
      SRC_DEN:   opb = den;
      SRC_INNOV: opb = innov;
      SRC_K1:    opb = k1;
      SRC_K2:    opb = k2;
      SRC_M:     opb = m;
      default:   opb = '0;
    endcase
  end

  assign alu_go    = (state == ST_EXEC) && (uc.op != OP_DIV);
  assign div_start = (state == ST_EXEC) && (uc.op == OP_DIV);

  kab_alu u_alu (
    .clk (clk),
    .go  (alu_go),
    .op  (uc.op),
    .a   (opa),
    .b   (opb),
    .res (alu_res)
  );

  kab_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (opa),
    .den   (opb),
    .stat  (div_stat),
    .quot  (div_res)
  );

  // write-back from the ALU or the divider
  assign wr_en = ((state == ST_WB) && uc.wr) || ((state == ST_DIV) && div_stat.done);
  assign wdata = (state == ST_DIV) ? div_res : alu_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_st <= '0;
      bias_st  <= '0;
      c00      <= WORD_ONE;
      c01      <= '0;
      c10      <= '0;
      c11      <= WORD_ONE;
    end else if (wr_en) begin
      unique case (uc.dst)
        SRC_ANGLE: angle_st <= wdata;
        SRC_BIAS:  bias_st  <= wdata;
        SRC_C00:   c00      <= wdata;
        SRC_C01:   c01      <= wdata;
        SRC_C10:   c10      <= wdata;
        SRC_C11:   c11      <= wdata;
        SRC_T:     t        <= wdata;
        SRC_ANGP:  angp     <= wdata;
        SRC_P11DT: p11dt    <= wdata;
        SRC_P00:   p00      <= wdata;
        SRC_P01:   p01      <= wdata;
        SRC_P10:   p10      <= wdata;
        SRC_P11:   p11      <= wdata;
        SRC_DEN:   den      <= wdata;
        SRC_INNOV: innov    <= wdata;
        SRC_K1:    k1       <= wdata;
        SRC_K2:    k2       <= wdata;
        SRC_M:     m        <= wdata;
        default: ;
      endcase
    end
  end

  // sample capture
  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      meas <= sample.data.measured_angle;
      rate <= sample.data.gyro_rate;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (sample.valid) begin
            state <= ST_EXEC;
            step  <= '0;
          end
        end
        ST_EXEC: begin
          state <= (uc.op == OP_DIV) ? ST_DIV : ST_WB;
        end
        ST_WB: begin
          if (step == STEP_LAST) begin
            state <= ST_EMIT;
          end else begin
            step  <= step + 1'b1;
            state <= ST_EXEC;
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            step  <= step + 1'b1;
            state <= ST_EXEC;
          end
        end
        ST_EMIT: begin
          if (!out_valid || estimate.ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register: load from hand-over, clear once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if ((state == ST_EMIT) && (!out_valid || estimate.ready)) begin
        out_valid <= 1'b1;
      end else if (estimate.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_EMIT) && (!out_valid || estimate.ready)) begin
      out_angle <= angle_st;
      out_bias  <= bias_st;
    end
  end

  assign sample.ready                  = (state == ST_IDLE);
  assign estimate.valid                = out_valid;
  assign estimate.data.angle_estimate  = out_angle;
  assign estimate.data.bias_estimate   = out_bias;

`ifndef SYNTH
  // an accepted sample starts the program at its first step
  a_start_step: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> (state == ST_EXEC && step == '0))
    else $error("sample accepted but micro-program did not start at step zero");

  // the divider is never restarted while it is still iterating
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // a divider result only arrives while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == ST_DIV))
    else $error("divider result outside the divide wait");

  // a new estimate word only appears from the hand-over state
  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    $rose(estimate.valid) |-> ($past(state) == ST_EMIT))
    else $error("estimate raised outside hand-over");
`endif

endmodule

`default_nettype wire
